// ===== hdl/spi_master_controller_core_assert.svh =====
// Assertion macros for the SPI master controller core.
// Used by spi_master_controller_core; expects aclk and aresetn in scope.
`ifndef SPI_MASTER_CONTROLLER_CORE_ASSERT_SVH
`define SPI_MASTER_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define SMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("SPI master controller check failed");

// Next-cycle implication, checked at every clock edge out of reset.
`define SMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("SPI master controller check failed");

`endif

// ===== hdl/smc_pkg.sv =====
// Shared types and constants for the SPI master controller core.
// No dependencies.
package smc_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [1:0] REQ_IDLE  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLARITY  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LSB_FIRST = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIXTEEN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAUD      = 3'd5;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] write_data;
        logic              miso;
    } smc_in_t;

    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              tx_empty;
        logic              rx_full;
        logic [WORD_W-1:0] read_data;
        logic              busy_res;
    } smc_out_t;

endpackage

// ===== hdl/spi_master_controller_core.sv =====
// SPI master controller core: bus requests, transmit/receive buffers and shifter.
// Depends on smc_pkg and spi_master_controller_core_assert.svh.
//
//   Channel  Ports                              Direction  Beat
//   input    s_valid s_ready s_data             in         one peripheral tick
//   result   m_valid m_ready m_data             out        line levels and status
//   config   cfg_valid cfg_ready cfg_index/data in         one register write
//
// Each input beat is one tick; a new beat is taken
// every cycle while the result register is empty or being drained.
// The result of a beat appears in the result register in the cycle after it is taken.
// A stalled result stops input acceptance; the engine advances only on input beats.
// Reset is synchronous and active low and clears all state and configuration but the result data.
// Configuration writes are always accepted and take effect on the next beat.
module spi_master_controller_core
    import smc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  smc_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output smc_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "spi_master_controller_core_assert.svh"

    logic              enable_reg;
    logic              phase_reg;
    logic              polarity_reg;
    logic              lsb_first_reg;
    logic              sixteen_reg;
    logic [2:0]        baud_reg;

    logic [WORD_W-1:0] tx_hold_reg, tx_hold_next;
    logic              tx_hold_full_reg, tx_hold_full_next;
    logic [WORD_W-1:0] shift_out_reg, shift_out_next;
    logic [WORD_W-1:0] shift_in_reg, shift_in_next;
    logic [WORD_W-1:0] rx_hold_reg, rx_hold_next;
    logic              rx_hold_full_reg, rx_hold_full_next;
    logic [4:0]        bits_left_reg, bits_left_next;
    logic [7:0]        prescale_count_reg, prescale_count_next;
    logic              clock_level_reg, clock_level_next;
    logic              frame_active_reg, frame_active_next;

    logic              m_valid_reg;
    smc_out_t          m_data_reg, m_data_next;

    logic              s_accept;
    logic [WORD_W-1:0] frame_mask;
    logic [4:0]        frame_len;
    logic [7:0]        threshold;
    logic [7:0]        prescale_inc;
    logic [WORD_W-1:0] sampled;
    logic [WORD_W-1:0] advanced;
    logic [4:0]        bits_dec;
    logic [WORD_W-1:0] read_word;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign frame_mask   = sixteen_reg ? 16'hFFFF : 16'h00FF;
    assign frame_len    = sixteen_reg ? 5'd16 : 5'd8;
    assign threshold    = 8'd1 << baud_reg;
    assign prescale_inc = prescale_count_reg + 8'd1;
    assign bits_dec     = (bits_left_reg != 5'd0) ? bits_left_reg - 5'd1 : 5'd0;

    always_comb begin
        if (lsb_first_reg) begin
            if (sixteen_reg) begin
                sampled = {s_data.miso, shift_in_reg[WORD_W-1:1]};
            end else begin
                sampled = {1'b0, shift_in_reg[WORD_W-1:9],
                           s_data.miso | shift_in_reg[8], shift_in_reg[7:1]};
            end
            advanced = {1'b0, shift_out_reg[WORD_W-1:1]};
        end else begin
            sampled  = {shift_in_reg[WORD_W-2:0], s_data.miso};
            advanced = {shift_out_reg[WORD_W-2:0], 1'b0};
        end
    end

    always_comb begin
        tx_hold_next        = tx_hold_reg;
        tx_hold_full_next   = tx_hold_full_reg;
        shift_out_next      = shift_out_reg;
        shift_in_next       = shift_in_reg;
        rx_hold_next        = rx_hold_reg;
        rx_hold_full_next   = rx_hold_full_reg;
        bits_left_next      = bits_left_reg;
        prescale_count_next = prescale_count_reg;
        clock_level_next    = clock_level_reg;
        frame_active_next   = frame_active_reg;
        read_word           = '0;

        case (s_data.req_type)
            REQ_WRITE: begin
                if (!tx_hold_full_reg) begin
                    tx_hold_next      = s_data.write_data;
                    tx_hold_full_next = 1'b1;
                end
            end
            REQ_READ: begin
                read_word         = rx_hold_reg;
                rx_hold_full_next = 1'b0;
            end
            default: begin
            end
        endcase

        if (!enable_reg) begin
            frame_active_next   = 1'b0;
            bits_left_next      = 5'd0;
            prescale_count_next = 8'd0;
            clock_level_next    = polarity_reg;
        end else if (!frame_active_reg) begin
            clock_level_next    = polarity_reg;
            prescale_count_next = 8'd0;
            if (tx_hold_full_next) begin
                shift_out_next    = tx_hold_next & frame_mask;
                tx_hold_full_next = 1'b0;
                shift_in_next     = '0;
                bits_left_next    = frame_len;
                frame_active_next = 1'b1;
            end
        end else if (prescale_inc >= threshold) begin
            prescale_count_next = 8'd0;
            clock_level_next    = !clock_level_reg;
            if (clock_level_reg == polarity_reg) begin
                if (!phase_reg) begin
                    shift_in_next = sampled;
                end else if (bits_left_reg != frame_len) begin
                    shift_out_next = advanced;
                end
            end else begin
                if (phase_reg) begin
                    shift_in_next = sampled;
                end
                bits_left_next = bits_dec;
                if (bits_dec == 5'd0) begin
                    rx_hold_next      = shift_in_next & frame_mask;
                    rx_hold_full_next = 1'b1;
                    frame_active_next = 1'b0;
                end else if (!phase_reg) begin
                    shift_out_next = advanced;
                end
            end
        end else begin
            prescale_count_next = prescale_inc;
        end

        m_data_next.sclk      = clock_level_next;
        m_data_next.mosi      = lsb_first_reg ? shift_out_next[0]
                              : (sixteen_reg ? shift_out_next[15] : shift_out_next[7]);
        m_data_next.tx_empty  = !tx_hold_full_next;
        m_data_next.rx_full   = rx_hold_full_next;
        m_data_next.read_data = read_word;
        m_data_next.busy_res  = frame_active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg         <= 1'b0;
            phase_reg          <= 1'b0;
            polarity_reg       <= 1'b0;
            lsb_first_reg      <= 1'b0;
            sixteen_reg        <= 1'b0;
            baud_reg           <= 3'd0;
            tx_hold_reg        <= '0;
            tx_hold_full_reg   <= 1'b0;
            shift_out_reg      <= '0;
            shift_in_reg       <= '0;
            rx_hold_reg        <= '0;
            rx_hold_full_reg   <= 1'b0;
            bits_left_reg      <= 5'd0;
            prescale_count_reg <= 8'd0;
            clock_level_reg    <= 1'b0;
            frame_active_reg   <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ENABLE:    enable_reg    <= cfg_data[0];
                    CFG_PHASE:     phase_reg     <= cfg_data[0];
                    CFG_POLARITY:  polarity_reg  <= cfg_data[0];
                    CFG_LSB_FIRST: lsb_first_reg <= cfg_data[0];
                    CFG_SIXTEEN:   sixteen_reg   <= cfg_data[0];
                    CFG_BAUD:      baud_reg      <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_accept) begin
                tx_hold_reg        <= tx_hold_next;
                tx_hold_full_reg   <= tx_hold_full_next;
                shift_out_reg      <= shift_out_next;
                shift_in_reg       <= shift_in_next;
                rx_hold_reg        <= rx_hold_next;
                rx_hold_full_reg   <= rx_hold_full_next;
                bits_left_reg      <= bits_left_next;
                prescale_count_reg <= prescale_count_next;
                clock_level_reg    <= clock_level_next;
                frame_active_reg   <= frame_active_next;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // A running frame always has bits left to shift.
    `SMC_ASSERT_NOW(a_frame_has_bits, frame_active_reg, bits_left_reg != 5'd0)
    // The prescaler never runs past the longest half period.
    `SMC_ASSERT_NOW(a_prescale_range, 1'b1, prescale_count_reg <= 8'd128)
    // A write beat to a free buffer is either held or already in the shifter.
    `SMC_ASSERT_NEXT(a_write_kept,
        s_accept && s_data.req_type == REQ_WRITE && !tx_hold_full_reg,
        tx_hold_full_reg || frame_active_reg)

endmodule
